@@ hw/rtl/mfadd_pkg.sv @@
// Shared constants and types for the minifloat adder.
// No dependencies; used by mfadd_core and minifloat_adder_truncating.
`default_nettype none
package mfadd_pkg;

  localparam int unsigned TotalWidthDef = 16;
  localparam int unsigned MantWidthDef  = 10;
  localparam int unsigned OpW           = 16;  // operand field width on the port
  localparam int unsigned SumW          = 16;  // sum field width on the port

  typedef enum logic [1:0] {
    CLS_FIN  = 2'd0,
    CLS_ZERO = 2'd1,
    CLS_INF  = 2'd2,
    CLS_NAN  = 2'd3
  } cls_e;

endpackage
`default_nettype wire

@@ hw/rtl/minifloat_adder_truncating.sv @@
// Minifloat adder top level: operand register, add core, result register.
// Depends on mfadd_pkg and mfadd_core.
`default_nettype none
// Adds two sign/biased-exponent/hidden-one operands (no subnormals) and truncates
// the sum toward zero. One operand pair is taken per cycle while s_axis_tready is high.
// A pair is captured in the operand register at its transfer; its result is captured in
// the result register once that register is empty or being taken, and is presented there
// until it is taken. The input stays ready while a finished result waits as long as the
// pipe has a free slot. The single add core sits between the two register stages.
module minifloat_adder_truncating #(
  parameter int unsigned TOTAL_WIDTH = mfadd_pkg::TotalWidthDef,
  parameter int unsigned MANT_WIDTH  = mfadd_pkg::MantWidthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // a_bits[15:0], b_bits[31:16]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata    // sum_bits[15:0], result_class[17:16], zero pad
);

  localparam int unsigned TW = TOTAL_WIDTH;

  logic          v1_q, v2_q, adv1, adv2;
  logic [TW-1:0] a_q, b_q, sum_c;
  mfadd_pkg::cls_e cls_c, cls_q;
  logic [mfadd_pkg::SumW-1:0] sum_q;

  assign adv2          = !v2_q || m_axis_tready;
  assign adv1          = !v1_q || adv2;
  assign s_axis_tready = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= s_axis_tvalid;
      if (adv2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && s_axis_tvalid) begin
      a_q <= TW'(s_axis_tdata[15:0]);
      b_q <= TW'(s_axis_tdata[31:16]);
    end
    if (adv2 && v1_q) begin
      sum_q <= mfadd_pkg::SumW'(sum_c);
      cls_q <= cls_c;
    end
  end

  mfadd_core #(
    .TW(TOTAL_WIDTH),
    .MW(MANT_WIDTH)
  ) u_core (
    .a_i  (a_q),
    .b_i  (b_q),
    .sum_o(sum_c),
    .cls_o(cls_c)
  );

  assign m_axis_tvalid = v2_q;
  assign m_axis_tdata  = {6'd0, cls_q, sum_q};

  a_full_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (v1_q && v2_q))
    else $error("input stalled with a free stage");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && adv2) |=> m_axis_tvalid)
    else $error("result lost between stages");

  // only the sign bit may be set on a zero result
  a_zero_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && cls_q == mfadd_pkg::CLS_ZERO) |->
      ((sum_q & ~(mfadd_pkg::SumW'(1) << (TW - 1))) == '0))
    else $error("zero class with nonzero magnitude");

endmodule
`default_nettype wire

@@ hw/rtl/mfadd_core.sv @@
// Combinational add of two minifloat operands, truncated toward zero.
// Depends on mfadd_pkg.
`default_nettype none
module mfadd_core #(
  parameter int unsigned TW = mfadd_pkg::TotalWidthDef,
  parameter int unsigned MW = mfadd_pkg::MantWidthDef
) (
  input  wire logic [TW-1:0]    a_i,
  input  wire logic [TW-1:0]    b_i,
  output logic      [TW-1:0]    sum_o,
  output mfadd_pkg::cls_e       cls_o
);

  localparam int unsigned EW = TW - 1 - MW;
  localparam int unsigned G  = MW + 3;
  localparam int unsigned W  = 2 * MW + 5;     // aligned significand plus carry
  localparam int unsigned LW = $clog2(W);
  localparam int unsigned XW = EW + LW + 2;    // signed result exponent

  logic          sa, sb, sx, sy;
  logic [EW-1:0] ea, eb, ex, ey, d;
  logic [MW-1:0] ma, mb, mx, my, mant;
  logic          a_max, b_max, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [W-1:0]  big, small_full, small_sh, r, norm;
  logic          lost;
  logic [LW-1:0] lz;
  logic signed [XW-1:0] er, emax_x;
  logic [TW-1:0] nan_enc, inf_enc;

  assign sa = a_i[TW-1];
  assign sb = b_i[TW-1];
  assign ea = a_i[TW-2:MW];
  assign eb = b_i[TW-2:MW];
  assign ma = a_i[MW-1:0];
  assign mb = b_i[MW-1:0];

  assign a_max  = &ea;
  assign b_max  = &eb;
  assign a_nan  = a_max && (ma != '0);
  assign b_nan  = b_max && (mb != '0);
  assign a_inf  = a_max && (ma == '0);
  assign b_inf  = b_max && (mb == '0);
  assign a_zero = (ea == '0) && (ma == '0);
  assign b_zero = (eb == '0) && (mb == '0);

  // x is the operand of larger magnitude
  always_comb begin
    if ({eb, mb} > {ea, ma}) begin
      sx = sb; ex = eb; mx = mb;
      sy = sa; ey = ea; my = ma;
    end else begin
      sx = sa; ex = ea; mx = ma;
      sy = sb; ey = eb; my = mb;
    end
  end

  assign d          = ex - ey;
  assign big        = W'({1'b1, mx}) << G;
  assign small_full = W'({1'b1, my}) << G;
  assign small_sh   = small_full >> d;
  assign lost       = ((small_sh << d) != small_full);
  // on subtraction take the ceiling of the shifted operand: the difference is an exact floor
  assign r = (sx == sy) ? (big + small_sh) : (big - small_sh - W'(lost));

  always_comb begin
    lz = '0;
    for (int i = 0; i < W; i++) begin
      if (r[i]) lz = LW'(W - 1 - i);
    end
  end

  assign norm   = r << lz;
  assign mant   = norm[W-2 -: MW];
  assign emax_x = XW'({EW{1'b1}});
  assign er     = $signed(XW'(ex)) + XW'(1) - $signed(XW'(lz));

  assign nan_enc = {1'b0, {EW{1'b1}}, {MW{1'b0}}} | (TW'(1) << (MW - 1));
  assign inf_enc = {1'b0, {EW{1'b1}}, {MW{1'b0}}};

  always_comb begin
    if (a_nan || b_nan || (a_inf && b_inf && (sa != sb))) begin
      sum_o = nan_enc;
      cls_o = mfadd_pkg::CLS_NAN;
    end else if (a_inf) begin
      sum_o = inf_enc | {sa, {(TW-1){1'b0}}};
      cls_o = mfadd_pkg::CLS_INF;
    end else if (b_inf) begin
      sum_o = inf_enc | {sb, {(TW-1){1'b0}}};
      cls_o = mfadd_pkg::CLS_INF;
    end else if (a_zero && b_zero) begin
      sum_o = '0;
      cls_o = mfadd_pkg::CLS_ZERO;
    end else if (a_zero) begin
      sum_o = b_i;
      cls_o = mfadd_pkg::CLS_FIN;
    end else if (b_zero) begin
      sum_o = a_i;
      cls_o = mfadd_pkg::CLS_FIN;
    end else if (r == '0) begin
      sum_o = '0;
      cls_o = mfadd_pkg::CLS_ZERO;
    end else if (er >= emax_x) begin
      sum_o = inf_enc | {sx, {(TW-1){1'b0}}};
      cls_o = mfadd_pkg::CLS_INF;
    end else if (er < 0 || (er == 0 && mant == '0)) begin
      sum_o = {sx, {(TW-1){1'b0}}};
      cls_o = mfadd_pkg::CLS_ZERO;
    end else begin
      sum_o = {sx, er[EW-1:0], mant};
      cls_o = mfadd_pkg::CLS_FIN;
    end
  end

endmodule
`default_nettype wire
